### hw/rtl/rmsl_pkg.sv
// Package for the sliding repeated median slope block.
// Holds the port widths, the default parameter values and the sequencer state type.
// Used by the top level and the port checker.
package rmsl_pkg;

   localparam int MAX_WINDOW_DEF  = 32;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int FRAC_BITS       = 8;
   localparam int SLOPE_BITS      = 25;
   localparam int FILL_BITS       = 6;
   localparam int LEN_BITS        = 6;
   localparam int LEN_MIN         = 2;
   localparam logic [LEN_BITS-1:0] LEN_RESET = 6'd8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_XK_RD,
      ST_XK_LD,
      ST_XJ_RD,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SEL_RD,
      ST_SEL_LD,
      ST_SEL_SCAN,
      ST_SEL_NEXT,
      ST_MED,
      ST_DONE
   } state_type;

endpackage

### hw/rtl/sliding_repeated_median_slope.sv
// Sliding repeated median slope: top level with sequencer and datapath.
// Depends on rmsl_pkg, rmsl_ram and rmsl_div.
//
// Each accepted item appends one sample to a history of MAX_WINDOW entries and
// produces one result: the Siegel repeated median slope (Q.8, signed 25 bits)
// over the W newest samples, W being the smaller of the samples seen so far and
// window_len clamped to 2..MAX_WINDOW, together with W itself. With W below two
// the slope is zero. A single iterative divider forms every pairwise slope, one
// quotient bit per cycle, and two comparators find each median by scanning
// a work memory one entry per cycle and counting the entries below and at each
// candidate. req_stall stays high while an item is in work, and an item with W
// below two skips the slope and median work. The block accepts the next item
// while the previous result still waits on rsp_stall. Write window_len through
// csr_wr_en/csr_wr_data only while the block is idle; it resets to 8.
module sliding_repeated_median_slope #(
   parameter int MAX_WINDOW  = rmsl_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = rmsl_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [rmsl_pkg::SLOPE_BITS-1:0] rsp_slope,
   output logic [rmsl_pkg::FILL_BITS-1:0]        rsp_window_fill,
   input  logic                                  csr_wr_en,
   input  logic [rmsl_pkg::LEN_BITS-1:0]         csr_wr_data
);

   import rmsl_pkg::*;

   localparam int AW   = $clog2(MAX_WINDOW);
   localparam int FW   = $clog2(MAX_WINDOW + 1);
   localparam int WAW  = $clog2(2 * MAX_WINDOW);
   localparam int SW   = SAMPLE_BITS + FRAC_BITS + 1;
   localparam int CW   = (SW > SLOPE_BITS) ? SW : SLOPE_BITS;
   localparam int CMPW = (FW > LEN_BITS) ? FW : LEN_BITS;
   localparam logic signed [CW-1:0] SAT_HI = {{(CW-SLOPE_BITS+1){1'b0}}, {(SLOPE_BITS-1){1'b1}}};
   localparam logic signed [CW-1:0] SAT_LO = {{(CW-SLOPE_BITS+1){1'b1}}, {(SLOPE_BITS-1){1'b0}}};

   // sequencer and datapath registers
   state_type               state_ff, state_in;
   logic [LEN_BITS-1:0]     len_ff, len_in;
   logic [AW-1:0]           wp_ff, wp_in;
   logic [FW-1:0]           fill_ff, fill_in;
   logic [FW-1:0]           w_ff, w_in;
   logic [AW-1:0]           start_ff, start_in;
   logic [AW-1:0]           k_ff, k_in;
   logic [AW-1:0]           j_ff, j_in;
   logic [AW-1:0]           cnt_ff, cnt_in;
   logic [AW-1:0]           i_ff, i_in;
   logic signed [SAMPLE_BITS-1:0] xk_ff, xk_in;
   logic                    region_ff, region_in;
   logic [FW-1:0]           seln_ff, seln_in;
   logic signed [SW-1:0]    cand_ff, cand_in;
   logic [FW-1:0]           lt_ff, lt_in;
   logic [FW-1:0]           le_ff, le_in;
   logic signed [SW-1:0]    vlo_ff, vlo_in;
   logic signed [SW-1:0]    vhi_ff, vhi_in;
   logic signed [SLOPE_BITS-1:0] res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SLOPE_BITS-1:0] rsp_slope_ff, rsp_slope_in;
   logic [FILL_BITS-1:0]    rsp_fill_ff, rsp_fill_in;

   // memories and divider hookup
   logic                    hist_we;
   logic [AW-1:0]           hist_raddr;
   logic [SAMPLE_BITS-1:0]  hist_rdata;
   logic                    wk_we;
   logic [WAW-1:0]          wk_waddr;
   logic [SW-1:0]           wk_wdata;
   logic [WAW-1:0]          wk_raddr;
   logic [SW-1:0]           wk_rdata;
   logic [AW-1:0]           wk_ridx;
   logic                    div_start;
   logic                    div_done;
   logic signed [SW-1:0]    div_quo;
   logic signed [SW-1:0]    div_num;
   logic [AW-1:0]           div_den;

   // helpers
   logic [AW-1:0]           wp_next;
   logic [FW-1:0]           fill_next;
   logic [CMPW-1:0]         len_ext;
   logic [CMPW-1:0]         span_c;
   logic [FW-1:0]           span;
   logic [FW-1:0]           w_new;
   logic [WAW-1:0]          start_sum;
   logic [AW-1:0]           start_new;
   logic [AW-1:0]           pt;
   logic [WAW-1:0]          pt_sum;
   logic                    j_last;
   logic                    k_last;
   logic                    i_last;
   logic                    sj_last;
   logic [FW-1:0]           n_last;
   logic [FW-1:0]           t_lo;
   logic [FW-1:0]           t_hi;
   logic signed [SAMPLE_BITS-1:0] xj;
   logic signed [SAMPLE_BITS:0]   diff;
   logic signed [SW-1:0]    scan_val;
   logic signed [SW:0]      med_sum;
   logic signed [SW-1:0]    med;
   logic signed [CW-1:0]    med_ext;
   logic signed [SLOPE_BITS-1:0] med_sat;
   logic                    rsp_free;

   rmsl_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_hist (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (wp_ff),
      .wr_data (req_sample),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   // lower half holds the per-point slopes, upper half the per-point medians
   rmsl_ram #(
      .WIDTH (SW),
      .DEPTH (2 * MAX_WINDOW)
   ) u_work (
      .clock   (clock),
      .wr_en   (wk_we),
      .wr_addr (wk_waddr),
      .wr_data (wk_wdata),
      .rd_addr (wk_raddr),
      .rd_data (wk_rdata)
   );

   rmsl_div #(
      .NW (SW),
      .DW (AW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // window bookkeeping for the item being accepted
   assign wp_next   = (wp_ff == AW'(MAX_WINDOW - 1)) ? '0 : wp_ff + AW'(1);
   assign fill_next = (fill_ff == FW'(MAX_WINDOW)) ? fill_ff : fill_ff + FW'(1);
   assign len_ext   = CMPW'(len_ff);
   assign span_c    = (len_ext < CMPW'(LEN_MIN)) ? CMPW'(LEN_MIN) :
                      (len_ext > CMPW'(MAX_WINDOW)) ? CMPW'(MAX_WINDOW) : len_ext;
   assign span      = FW'(span_c);
   assign w_new     = (fill_next < span) ? fill_next : span;
   assign start_sum = WAW'(wp_next) + WAW'(MAX_WINDOW) - WAW'(w_new);
   assign start_new = (start_sum >= WAW'(MAX_WINDOW)) ?
                      AW'(start_sum - WAW'(MAX_WINDOW)) : AW'(start_sum);

   // window point (0 = oldest) to history address
   assign pt         = (state_ff == ST_XK_RD) ? k_ff : j_ff;
   assign pt_sum     = WAW'(start_ff) + WAW'(pt);
   assign hist_raddr = (pt_sum >= WAW'(MAX_WINDOW)) ?
                       AW'(pt_sum - WAW'(MAX_WINDOW)) : AW'(pt_sum);

   assign j_last  = FW'(j_ff) == (w_ff - FW'(1));
   assign k_last  = FW'(k_ff) == (w_ff - FW'(1));
   assign n_last  = seln_ff - FW'(1);
   assign i_last  = FW'(i_ff) == n_last;
   assign sj_last = FW'(j_ff) == n_last;
   assign t_lo    = n_last >> 1;
   assign t_hi    = seln_ff >> 1;

   // pairwise slope operands, always newer minus older over a positive distance
   assign xj      = $signed(hist_rdata);
   assign diff    = (j_ff > k_ff) ? ((SAMPLE_BITS+1)'(xj) - (SAMPLE_BITS+1)'(xk_ff)) :
                                    ((SAMPLE_BITS+1)'(xk_ff) - (SAMPLE_BITS+1)'(xj));
   assign div_num = {diff, {FRAC_BITS{1'b0}}};
   assign div_den = (j_ff > k_ff) ? (j_ff - k_ff) : (k_ff - j_ff);

   assign wk_raddr = WAW'(wk_ridx) + (region_ff ? WAW'(MAX_WINDOW) : '0);
   assign scan_val = $signed(wk_rdata);

   // median of the two order statistics, floor of the mean
   assign med_sum = (SW+1)'(vlo_ff) + (SW+1)'(vhi_ff);
   assign med     = SW'(med_sum >>> 1);
   assign med_ext = CW'(med);
   assign med_sat = (med_ext > SAT_HI) ? SLOPE_BITS'(SAT_HI) :
                    (med_ext < SAT_LO) ? SLOPE_BITS'(SAT_LO) : SLOPE_BITS'(med_ext);

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (w_new < FW'(2)) ? ST_DONE : ST_XK_RD;
            end
         end
         ST_XK_RD:    state_in = ST_XK_LD;
         ST_XK_LD:    state_in = ST_XJ_RD;
         ST_XJ_RD: begin
            if (j_ff == k_ff) begin
               state_in = j_last ? ST_SEL_RD : ST_XJ_RD;
            end else begin
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = j_last ? ST_SEL_RD : ST_XJ_RD;
            end
         end
         ST_SEL_RD:   state_in = ST_SEL_LD;
         ST_SEL_LD:   state_in = ST_SEL_SCAN;
         ST_SEL_SCAN: state_in = sj_last ? ST_SEL_NEXT : ST_SEL_SCAN;
         ST_SEL_NEXT: state_in = i_last ? ST_MED : ST_SEL_RD;
         ST_MED: begin
            if (region_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = k_last ? ST_SEL_RD : ST_XK_RD;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // controls and datapath next values
   always_comb begin
      len_in       = csr_wr_en ? csr_wr_data : len_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      w_in         = w_ff;
      start_in     = start_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      xk_in        = xk_ff;
      region_in    = region_ff;
      seln_in      = seln_ff;
      cand_in      = cand_ff;
      lt_in        = lt_ff;
      le_in        = le_ff;
      vlo_in       = vlo_ff;
      vhi_in       = vhi_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_slope_in = rsp_slope_ff;
      rsp_fill_in  = rsp_fill_ff;
      hist_we      = 1'b0;
      wk_we        = 1'b0;
      wk_waddr     = WAW'(cnt_ff);
      wk_wdata     = div_quo;
      wk_ridx      = i_ff;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // store the sample and fix the window for this item
               hist_we  = 1'b1;
               wp_in    = wp_next;
               fill_in  = fill_next;
               w_in     = w_new;
               start_in = start_new;
               k_in     = '0;
               res_in   = '0;
            end
         end
         ST_XK_RD: begin
         end
         ST_XK_LD: begin
            xk_in  = $signed(hist_rdata);
            j_in   = '0;
            cnt_in = '0;
         end
         ST_XJ_RD: begin
            if (j_ff == k_ff) begin
               // skip the point itself
               if (j_last) begin
                  seln_in   = w_ff - FW'(1);
                  region_in = 1'b0;
                  i_in      = '0;
               end else begin
                  j_in = j_ff + AW'(1);
               end
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               wk_we  = 1'b1;
               cnt_in = cnt_ff + AW'(1);
               if (j_last) begin
                  seln_in   = w_ff - FW'(1);
                  region_in = 1'b0;
                  i_in      = '0;
               end else begin
                  j_in = j_ff + AW'(1);
               end
            end
         end
         ST_SEL_RD: begin
            wk_ridx = i_ff;
         end
         ST_SEL_LD: begin
            cand_in = scan_val;
            wk_ridx = '0;
            j_in    = '0;
            lt_in   = '0;
            le_in   = '0;
         end
         ST_SEL_SCAN: begin
            // count entries below and at the candidate
            lt_in   = lt_ff + FW'(scan_val < cand_ff);
            le_in   = le_ff + FW'(scan_val <= cand_ff);
            wk_ridx = j_ff + AW'(1);
            j_in    = j_ff + AW'(1);
         end
         ST_SEL_NEXT: begin
            if (lt_ff <= t_lo && t_lo < le_ff) begin
               vlo_in = cand_ff;
            end
            if (lt_ff <= t_hi && t_hi < le_ff) begin
               vhi_in = cand_ff;
            end
            i_in = i_ff + AW'(1);
         end
         ST_MED: begin
            if (region_ff) begin
               res_in = med_sat;
            end else begin
               wk_we    = 1'b1;
               wk_waddr = WAW'(k_ff) + WAW'(MAX_WINDOW);
               wk_wdata = med;
               if (k_last) begin
                  seln_in   = w_ff;
                  region_in = 1'b1;
                  i_in      = '0;
               end else begin
                  k_in = k_ff + AW'(1);
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_slope_in = res_ff;
               rsp_fill_in  = FILL_BITS'(w_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LEN_RESET;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      w_ff         <= w_in;
      start_ff     <= start_in;
      k_ff         <= k_in;
      j_ff         <= j_in;
      cnt_ff       <= cnt_in;
      i_ff         <= i_in;
      xk_ff        <= xk_in;
      region_ff    <= region_in;
      seln_ff      <= seln_in;
      cand_ff      <= cand_in;
      lt_ff        <= lt_in;
      le_ff        <= le_in;
      vlo_ff       <= vlo_in;
      vhi_ff       <= vhi_in;
      res_ff       <= res_in;
      rsp_slope_ff <= rsp_slope_in;
      rsp_fill_ff  <= rsp_fill_in;
   end

   assign req_stall       = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slope       = rsp_slope_ff;
   assign rsp_window_fill = rsp_fill_ff;

endmodule

### hw/rtl/rmsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rmsl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/rmsl_div.sv
// Iterative signed divider, one quotient bit per cycle, quotient rounded toward
// negative infinity. Divisor is a positive unsigned value. No dependencies.
module rmsl_div #(
   parameter int NW = 25,
   parameter int DW = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [NW-1:0] num,
   input  logic [DW-1:0]        den,
   output logic                 done,
   output logic signed [NW-1:0] quo
);

   localparam int CNW = $clog2(NW + 1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]  q_ff, q_in;
   logic [DW-1:0]  rem_ff, rem_in;
   logic [DW-1:0]  den_ff, den_in;
   logic           neg_ff, neg_in;
   logic [DW:0]    rem_sh;
   logic [DW:0]    rem_sub;
   logic           ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      rem_sh  = {rem_ff, q_ff[NW-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      ge      = rem_sh >= {1'b0, den_ff};
      if (start) begin
         // load the magnitude; the sign is applied at the end
         busy_in = 1'b1;
         cnt_in  = CNW'(NW);
         q_in    = num[NW-1] ? (~num + NW'(1)) : num;
         rem_in  = '0;
         den_in  = den;
         neg_in  = num[NW-1];
      end else if (busy_ff) begin
         q_in   = {q_ff[NW-2:0], ge};
         rem_in = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
         cnt_in = cnt_ff - CNW'(1);
         if (cnt_ff == CNW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // negative with a remainder rounds one further down
   assign quo  = neg_ff ? ((rem_ff != '0) ? ~q_ff : (~q_ff + NW'(1))) : q_ff;
   assign done = done_ff;

endmodule

### hw/rtl/rmsl_chk.sv
// Port checker for the sliding repeated median slope block, bound to the top level.
// Depends on rmsl_pkg.
module rmsl_chk (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [rmsl_pkg::SLOPE_BITS-1:0] rsp_slope,
   input logic [rmsl_pkg::FILL_BITS-1:0]        rsp_window_fill
);

   import rmsl_pkg::*;

   // an accepted item keeps the block busy on the next cycle
   a_busy_after_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block ready right after taking an item");

   // a short window gives a zero slope
   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_window_fill < FILL_BITS'(2)) |-> rsp_slope == '0)
      else $error("nonzero slope with fewer than two samples");

   // a new result only comes out of a busy block
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work in progress");

   // hold a stalled result
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slope) && $stable(rsp_window_fill))
      else $error("stalled result changed");

endmodule

bind sliding_repeated_median_slope rmsl_chk u_rmsl_chk (.*);
